// File: rtl/core/hrsv_pkg.sv
// ----------------------------------------------------------------------------
// hrsv_pkg
// Shared types and constants for the hashed read seed verify unit.
// ----------------------------------------------------------------------------
package hrsv_pkg;

  localparam int HASH_BITS       = 16;
  localparam int CANDIDATE_DEPTH = 65536;
  localparam int REFERENCE_WORDS = 65536;
  localparam int BKT_DEPTH       = 65536;

  localparam int BKT_AW  = $clog2(BKT_DEPTH);
  localparam int CAND_AW = $clog2(CANDIDATE_DEPTH);
  localparam int REF_AW  = $clog2(REFERENCE_WORDS);
  localparam int IDX_W   = 17;

  // Five reference words cover three full words plus the tail byte at any offset.
  localparam int REF_SPAN = 5;
  localparam int K_W      = $clog2(REF_SPAN + 1);

  localparam logic [1:0] CMD_WR_BUCKET = 2'd0;
  localparam logic [1:0] CMD_WR_CAND   = 2'd1;
  localparam logic [1:0] CMD_WR_REF    = 2'd2;
  localparam logic [1:0] CMD_ALIGN     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [63:0] write_data;
    logic [63:0] read_word0;
    logic [63:0] read_word1;
    logic [63:0] read_word2;
    logic [7:0]  read_tail;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] position;
    logic [31:0] occurrence_count;
  } out_item_t;

  typedef struct packed {
    logic           bkt_hi;
    logic           ld_start;
    logic           ld_end;
    logic           inc_idx;
    logic           ld_entry;
    logic           ref_issue;
    logic [K_W-1:0] ref_k;
    logic           set_hit;
    logic           out_load;
  } hrsv_cmd_t;

  typedef struct packed {
    logic in_align;
    logic idx_lt_end;
    logic ref_ok;
    logic ref_bad;
  } hrsv_sts_t;

endpackage

// File: rtl/core/hrsv_ram.sv
// ----------------------------------------------------------------------------
// hrsv_ram
// Generic single-port RAM with a registered read, read-before-write.
// ----------------------------------------------------------------------------
module hrsv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/hrsv_dp.sv
// ----------------------------------------------------------------------------
// hrsv_dp
// Datapath: the three stores, bucket bounds, candidate walk and the
// funnel-shift compare of reference windows against the read.
// ----------------------------------------------------------------------------
module hrsv_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  hrsv_pkg::in_item_t in_data,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_data,
  input  hrsv_pkg::hrsv_cmd_t cmd,
  output hrsv_pkg::hrsv_sts_t sts,
  output hrsv_pkg::out_item_t out_data
);
  import hrsv_pkg::*;

  logic [IDX_W-1:0]  total_r;
  logic [63:0]       rd0_r, rd1_r, rd2_r;
  logic [7:0]        tail_r;
  logic [IDX_W-1:0]  cur_idx_r, end_r;
  logic [63:0]       entry_r;
  logic              hit_r;
  logic              rvalid_r;
  logic [K_W-1:0]    ridx_r;
  logic [63:0]       prev_r;
  out_item_t         out_r;

  logic [HASH_BITS-1:0] hash, hash_p1;
  logic                 hash_last;
  logic                 bkt_we, cand_we, ref_we;
  logic [BKT_AW-1:0]    bkt_addr;
  logic [CAND_AW-1:0]   cand_addr;
  logic [REF_AW-1:0]    ref_addr;
  logic [IDX_W-1:0]     bkt_rdata;
  logic [63:0]          cand_rdata, ref_rdata;
  logic [127:0]         shifted;
  logic [63:0]          win;
  logic                 eq;

  assign hash      = rd0_r[63 -: HASH_BITS];
  assign hash_p1   = hash + HASH_BITS'(1);
  assign hash_last = &hash;

  assign bkt_we  = in_accept && (in_data.command == CMD_WR_BUCKET);
  assign cand_we = in_accept && (in_data.command == CMD_WR_CAND);
  assign ref_we  = in_accept && (in_data.command == CMD_WR_REF);

  always_comb begin
    if (bkt_we) begin
      bkt_addr = BKT_AW'(in_data.address);
    end else if (cmd.bkt_hi) begin
      bkt_addr = BKT_AW'(hash_p1);
    end else begin
      bkt_addr = BKT_AW'(hash);
    end
  end

  assign cand_addr = cand_we ? CAND_AW'(in_data.address) : CAND_AW'(cur_idx_r);

  // Reference word address wraps with the store: base word plus word offset.
  assign ref_addr = ref_we ? REF_AW'(in_data.address)
                           : entry_r[5 +: REF_AW] + REF_AW'(cmd.ref_k);

  hrsv_ram #(.WIDTH(IDX_W), .DEPTH(BKT_DEPTH)) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_we),
    .addr  (bkt_addr),
    .wdata (in_data.write_data[IDX_W-1:0]),
    .rdata (bkt_rdata)
  );

  hrsv_ram #(.WIDTH(64), .DEPTH(CANDIDATE_DEPTH)) u_cand_ram (
    .clk   (clk),
    .we    (cand_we),
    .addr  (cand_addr),
    .wdata (in_data.write_data),
    .rdata (cand_rdata)
  );

  hrsv_ram #(.WIDTH(64), .DEPTH(REFERENCE_WORDS)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .addr  (ref_addr),
    .wdata (in_data.write_data),
    .rdata (ref_rdata)
  );

  // Window for word j is the pair (word j+1, word j) shifted right by two bits
  // per base of offset; word j+1 arrives while word j waits in prev_r.
  assign shifted = {ref_rdata, prev_r} >> {entry_r[4:0], 1'b0};
  assign win     = shifted[63:0];

  always_comb begin
    case (ridx_r)
      K_W'(1):  eq = (win == rd0_r);
      K_W'(2):  eq = (win == rd1_r);
      K_W'(3):  eq = (win == rd2_r);
      K_W'(4):  eq = (win[7:0] == tail_r);
      default:  eq = 1'b1;
    endcase
  end

  assign sts.in_align   = (in_data.command == CMD_ALIGN);
  assign sts.idx_lt_end = (cur_idx_r < end_r);
  assign sts.ref_ok     = rvalid_r && (ridx_r == K_W'(REF_SPAN - 1)) && eq;
  assign sts.ref_bad    = rvalid_r && (ridx_r != '0) && !eq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_data;
      end
      rvalid_r <= cmd.ref_issue;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cmd.ref_k;
    if (rvalid_r) begin
      prev_r <= ref_rdata;
    end
    if (in_accept && sts.in_align) begin
      rd0_r  <= in_data.read_word0;
      rd1_r  <= in_data.read_word1;
      rd2_r  <= in_data.read_word2;
      tail_r <= in_data.read_tail;
      hit_r  <= 1'b0;
    end else if (cmd.set_hit) begin
      hit_r <= 1'b1;
    end
    if (cmd.ld_start) begin
      cur_idx_r <= bkt_rdata;
    end else if (cmd.inc_idx) begin
      cur_idx_r <= cur_idx_r + IDX_W'(1);
    end
    if (cmd.ld_end) begin
      end_r <= hash_last ? total_r : bkt_rdata;
    end
    if (cmd.ld_entry) begin
      entry_r <= cand_rdata;
    end
    if (cmd.out_load) begin
      out_r.found            <= hit_r;
      out_r.position         <= hit_r ? entry_r[31:0] : '0;
      out_r.occurrence_count <= hit_r ? entry_r[63:32] : '0;
    end
  end

  assign out_data = out_r;

endmodule

// File: rtl/core/hrsv_ctrl.sv
// ----------------------------------------------------------------------------
// hrsv_ctrl
// Controller: sequences bucket lookup, candidate walk, reference reads and
// the result transfer.
// ----------------------------------------------------------------------------
module hrsv_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  hrsv_pkg::hrsv_sts_t sts,
  input  logic                out_stall,
  output logic                in_stall,
  output logic                out_valid,
  output hrsv_pkg::hrsv_cmd_t cmd
);
  import hrsv_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BKT_S  = 4'd1;
  localparam logic [3:0] S_BKT_E  = 4'd2;
  localparam logic [3:0] S_BKT_W  = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_CAND   = 4'd5;
  localparam logic [3:0] S_CAND_W = 4'd6;
  localparam logic [3:0] S_REF    = 4'd7;
  localparam logic [3:0] S_RES    = 4'd8;

  logic [3:0]     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.ref_k     = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && sts.in_align) begin
          state_nxt = S_BKT_S;
        end
      end
      S_BKT_S: begin
        state_nxt = S_BKT_E;
      end
      S_BKT_E: begin
        cmd.bkt_hi   = 1'b1;
        cmd.ld_start = 1'b1;
        state_nxt    = S_BKT_W;
      end
      S_BKT_W: begin
        cmd.ld_end = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        state_nxt = sts.idx_lt_end ? S_CAND : S_RES;
      end
      S_CAND: begin
        state_nxt = S_CAND_W;
      end
      S_CAND_W: begin
        cmd.ld_entry = 1'b1;
        k_nxt        = '0;
        state_nxt    = S_REF;
      end
      S_REF: begin
        if (k_r < K_W'(REF_SPAN)) begin
          cmd.ref_issue = 1'b1;
          k_nxt         = k_r + K_W'(1);
        end
        if (sts.ref_bad) begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_NEXT;
        end else if (sts.ref_ok) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/hashed_read_seed_verify_unit.sv
// ----------------------------------------------------------------------------
// hashed_read_seed_verify_unit
// Hash-indexed exact alignment of 100-base reads against a packed reference.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_item_t (command, stores, read)
//   out_     output     out_valid/out_stall out_item_t (found, position, count)
//   cfg_     input      cfg_valid/cfg_ready candidate total, 17 bits
//
// Store writes leave the unit idle. An align tries candidates in turn: each
// candidate costs one table read and up to five reads of the single-port
// reference RAM, stopping at the first mismatching word. Reset clears control
// state and the candidate total only; the stores hold nothing defined until
// written. A stalled result waits in the output register; the next item is
// taken once it is loaded there.
// ----------------------------------------------------------------------------
module hashed_read_seed_verify_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrsv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrsv_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [16:0]         cfg_data
);
  import hrsv_pkg::*;

  hrsv_cmd_t cmd;
  hrsv_sts_t sts;
  logic      in_accept;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  hrsv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .sts       (sts),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hrsv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // An align transfer always makes the unit busy on the next cycle.
  a_align_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_data.command == CMD_ALIGN) |=> in_stall)
    else $error("align accepted but unit not busy");

  // Store writes complete at once and leave the unit ready.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_data.command != CMD_ALIGN) |=> !in_stall)
    else $error("store write left the unit busy");

  // A miss reports zero position and count.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.position == '0) && (out_data.occurrence_count == '0))
    else $error("miss result carries nonzero fields");

endmodule
